FILE: hdl/mavt_pkg.sv
package mavt_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSB_BITS_USED   = 1'd1;

    localparam logic [4:0] RES_RESET = 5'd12;
    localparam logic [4:0] RES_MIN   = 5'd8;
    localparam logic [4:0] RES_MAX   = 5'd16;
    localparam logic [3:0] MSB_RESET = 4'd4;
    localparam logic [3:0] MSB_MAX   = 4'd8;

    // 2*pi truncated to Q28
    localparam logic [30:0] TWO_PI_Q28 = 31'h6487_ED51;
    localparam logic [19:0] US_PER_S   = 20'd1000000;
    localparam logic [31:0] DT_MAX     = 32'd500000;
    localparam logic [18:0] DT_DEFAULT = 19'd1000;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // velocity divider: radix-4 restoring, numerator fits 54 bits, dt below 2^19
    localparam int DIV_NUM_W = 54;
    localparam int DIV_DEN_W = 19;
    localparam int DIV_STEPS = DIV_NUM_W / 2;

    typedef enum logic [1:0] {
        OP_SAMPLE     = 2'd0,
        OP_SET_ZERO   = 2'd1,
        OP_CLEAR_ZERO = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  msb_byte;
        logic [7:0]  lsb_byte;
        logic [31:0] time_us;
    } t_in;

    typedef struct packed {
        logic signed [31:0] angle_rad;
        logic signed [31:0] velocity_rad_s;
        logic signed [31:0] zero_shift_rad;
    } t_out;

    typedef struct packed {
        t_op         op;
        logic [15:0] raw_count;
        logic [31:0] time_us;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic [4:0] res_clamp(input logic [4:0] r);
        logic [4:0] v;
        v = r;
        if (v < RES_MIN) v = RES_MIN;
        if (v > RES_MAX) v = RES_MAX;
        return v;
    endfunction

    function automatic logic [3:0] msb_clamp(input logic [3:0] m);
        return (m > MSB_MAX) ? MSB_MAX : m;
    endfunction

    // sign and magnitude to saturated Q value
    function automatic logic signed [31:0] sat_q(input logic neg, input logic [63:0] mag);
        logic signed [31:0] r;
        if (neg) begin
            r = (mag > 64'h8000_0000) ? Q_MIN : -$signed(mag[31:0]);
        end else begin
            r = (mag > 64'h7FFF_FFFF) ? Q_MAX : $signed(mag[31:0]);
        end
        return r;
    endfunction

endpackage

FILE: hdl/mavt_front.sv
module mavt_front (
    input  logic [4:0]     i_res,
    input  logic [3:0]     i_mb,
    input  logic           i_push,
    input  logic           i_full,
    input  mavt_pkg::t_in  i_in,
    output logic           o_wr,
    output mavt_pkg::t_job o_job
);
    import mavt_pkg::*;

    logic [4:0]  low_bits;
    logic [7:0]  lmask;
    logic [7:0]  mmask;
    logic [24:0] lpart;
    logic [24:0] mpart;
    logic [24:0] sum;
    logic [15:0] res_mask;

    // raw count from the two register bytes
    always_comb begin
        low_bits = (5'(i_mb) > i_res) ? 5'd0 : i_res - 5'(i_mb);
        lmask    = (low_bits >= 5'd8) ? 8'hFF : 8'((9'd1 << low_bits) - 9'd1);
        mmask    = 8'((9'd1 << i_mb) - 9'd1);
        lpart    = 25'(i_in.lsb_byte & lmask);
        mpart    = 25'(i_in.msb_byte & mmask) << low_bits;
        sum      = lpart + mpart;
        res_mask = 16'((17'd1 << i_res) - 17'd1);

        o_job.op        = t_op'(i_in.op);
        o_job.raw_count = sum[15:0] & res_mask;
        o_job.time_us   = i_in.time_us;
        o_wr            = i_push & ~i_full;
    end

endmodule

FILE: hdl/mavt_queue.sv
module mavt_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  mavt_pkg::t_job   i_data,
    input  logic             i_rd,
    output mavt_pkg::t_job   o_data,
    output mavt_pkg::t_qstat o_stat
);
    import mavt_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign do_wr       = i_wr & ~o_stat.full;
    assign do_rd       = i_rd & ~o_stat.empty;
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/mavt_back.sv
module mavt_back #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [4:0]     i_res,
    input  logic           i_q_empty,
    input  mavt_pkg::t_job i_job,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output mavt_pkg::t_out o_out
);
    import mavt_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TRACK = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_SCALE = 8'b0000_1000,
        S_VMUL  = 8'b0001_0000,
        S_VADD  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                 r_state;
    t_job                   r_job;
    logic [15:0]            r_last_raw;
    logic signed [15:0]     r_turn;
    logic [15:0]            r_zero;
    logic signed [31:0]     r_last_angle;
    logic [31:0]            r_last_time;
    logic signed [33:0]     r_t;
    logic [DIV_DEN_W-1:0]   r_dt;
    logic [62:0]            r_prod;
    logic                   r_neg;
    logic signed [31:0]     r_ang;
    logic signed [31:0]     r_shift;
    logic [DIV_NUM_W-1:0]   r_num;
    logic [DIV_DEN_W-1:0]   r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_vneg;
    logic                   r_out_valid;
    t_out                   r_out;

    // turn tracking
    logic signed [16:0]     trk_d;
    logic [15:0]            trk_ad;
    logic [18:0]            trk_ad5;
    logic [18:0]            trk_lim;
    logic signed [15:0]     trk_turn;
    logic signed [33:0]     trk_t;
    logic [31:0]            dt_raw;
    logic [DIV_DEN_W-1:0]   dt_eff;
    // scaling
    logic [31:0]            mul_mag;
    logic [5:0]             sh;
    logic [63:0]            rnd;
    logic [63:0]            scaled;
    logic signed [31:0]     ang;
    // velocity
    logic signed [32:0]     vdiff;
    logic [32:0]            vmag;
    logic [DIV_DEN_W:0]     s1;
    logic [DIV_DEN_W:0]     s2;
    logic [DIV_DEN_W:0]     den;
    logic                   ge1;
    logic                   ge2;
    logic [DIV_DEN_W:0]     rem1;
    logic [DIV_DEN_W:0]     rem2;
    logic signed [31:0]     vel;
    logic                   load;

    always_comb begin
        trk_d    = $signed({1'b0, r_job.raw_count}) - $signed({1'b0, r_last_raw});
        trk_ad   = trk_d[16] ? 16'(-trk_d) : trk_d[15:0];
        trk_ad5  = {3'b0, trk_ad} + ({3'b0, trk_ad} << 2);
        trk_lim  = 19'(19'd4 << i_res);
        trk_turn = r_turn;
        if (trk_ad5 > trk_lim) begin
            // a large jump up in count means a turn backwards, a large jump down a turn forwards
            trk_turn = trk_d[16] ? r_turn + 16'sd1 : r_turn - 16'sd1;
        end
        if (r_job.op == OP_CLEAR_ZERO) begin
            trk_t = -$signed({18'd0, r_zero});
        end else begin
            trk_t = ($signed(34'(trk_turn)) <<< i_res) + $signed({18'd0, r_job.raw_count})
                  - $signed({18'd0, r_zero});
        end
        dt_raw = r_job.time_us - r_last_time;
        dt_eff = (dt_raw == 32'd0 || dt_raw > DT_MAX) ? DT_DEFAULT : dt_raw[DIV_DEN_W-1:0];

        mul_mag = r_t[33] ? 32'(-r_t) : r_t[31:0];
        sh      = 6'(i_res) + 6'(28 - ANGLE_FRAC_BITS);
        rnd     = {1'b0, r_prod} + (64'd1 << (sh - 6'd1));
        scaled  = rnd >> sh;
        ang     = sat_q(r_neg, scaled);

        vdiff = $signed({r_ang[31], r_ang}) - $signed({r_last_angle[31], r_last_angle});
        vmag  = vdiff[32] ? 33'(-vdiff) : vdiff;

        den  = {1'b0, r_dt};
        s1   = {r_rem, r_num[DIV_NUM_W-1]};
        ge1  = (s1 >= den);
        rem1 = ge1 ? s1 - den : s1;
        s2   = {rem1[DIV_DEN_W-1:0], r_num[DIV_NUM_W-2]};
        ge2  = (s2 >= den);
        rem2 = ge2 ? s2 - den : s2;

        vel  = sat_q(r_vneg, 64'(r_num));
        load = (r_state == S_DONE) && (!r_out_valid || i_pop);
    end

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty = ~r_out_valid;
    assign o_out   = r_out;

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_last_raw   <= '0;
            r_turn       <= '0;
            r_zero       <= '0;
            r_last_angle <= '0;
            r_last_time  <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) r_state <= S_TRACK;
                end
                S_TRACK: begin
                    case (r_job.op)
                        OP_SAMPLE: begin
                            r_last_raw <= r_job.raw_count;
                            r_turn     <= trk_turn;
                            r_state    <= S_MUL;
                        end
                        OP_SET_ZERO: begin
                            r_last_raw <= r_job.raw_count;
                            r_turn     <= '0;
                            r_zero     <= r_job.raw_count;
                            r_state    <= S_MUL;
                        end
                        OP_CLEAR_ZERO: begin
                            r_turn  <= '0;
                            r_zero  <= '0;
                            r_state <= S_MUL;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MUL: r_state <= S_SCALE;
                S_SCALE: begin
                    r_state <= (r_job.op == OP_SAMPLE) ? S_VMUL : S_DONE;
                end
                S_VMUL: begin
                    r_last_angle <= r_ang;
                    r_last_time  <= r_job.time_us;
                    r_state      <= S_VADD;
                end
                S_VADD: r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
            end
            S_TRACK: begin
                r_t  <= trk_t;
                r_dt <= dt_eff;
            end
            S_MUL: begin
                r_neg  <= r_t[33];
                r_prod <= mul_mag * TWO_PI_Q28;
            end
            S_SCALE: begin
                r_ang   <= ang;
                r_shift <= (r_job.op == OP_SET_ZERO) ? ((ang == Q_MIN) ? Q_MAX : -ang) : ang;
            end
            S_VMUL: begin
                r_vneg <= vdiff[32];
                r_num  <= DIV_NUM_W'(vmag * US_PER_S);
            end
            S_VADD: begin
                r_num <= r_num + DIV_NUM_W'(r_dt >> 1);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_num <= {r_num[DIV_NUM_W-3:0], ge1, ge2};
                r_rem <= rem2[DIV_DEN_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
            S_DONE: begin
                if (load) begin
                    case (r_job.op)
                        OP_SAMPLE: begin
                            r_out.angle_rad      <= r_ang;
                            r_out.velocity_rad_s <= vel;
                            r_out.zero_shift_rad <= '0;
                        end
                        OP_SET_ZERO, OP_CLEAR_ZERO: begin
                            r_out.angle_rad      <= '0;
                            r_out.velocity_rad_s <= '0;
                            r_out.zero_shift_rad <= r_shift;
                        end
                        default: begin
                            r_out <= '0;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/multiturn_angle_velocity_tracker_core.sv
// Multi-turn angle and velocity tracker for a magnetic angle sensor. Push one item per
// sensor read: op, the two angle register bytes and a free running microsecond stamp.
// Each item gives exactly one result, popped from the result side: multi-turn angle and
// velocity in signed Q(32-ANGLE_FRAC_BITS).ANGLE_FRAC_BITS radians, saturating, plus the
// angle shift reported by the two zero operations. A count jump of more than 0.8 rev is
// taken as a wrap. A time step of zero or above 0.5 s is taken as 1 ms. The front end
// builds the raw count as the item is pushed and parks it in a QUEUE_DEPTH-entry queue;
// the back end then runs a scaling multiply for a sample or zero operation, and for a
// sample also a velocity multiply and a 27-step radix-4 restoring divider; it takes no
// new item until the last result is in the output register. Results wait there, so the
// queue keeps filling while the consumer stalls. Write configuration only while idle.
module multiturn_angle_velocity_tracker_core #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int QUEUE_DEPTH     = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item side
    input  logic                              i_push,
    output logic                              o_full,
    input  mavt_pkg::t_in                     i_in,
    // result side
    output logic                              o_empty,
    input  logic                              i_pop,
    output mavt_pkg::t_out                    o_out,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [mavt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mavt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mavt_pkg::*;

    logic [4:0] r_res_bits;
    logic [3:0] r_msb_bits;
    logic [4:0] res_eff;
    logic [3:0] mb_eff;

    logic   front_wr;
    t_job   front_job;
    t_job   q_job;
    t_qstat q_stat;
    logic   q_pop;

    // config registers, clamped to their legal ranges on use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_bits <= RES_RESET;
            r_msb_bits <= MSB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RESOLUTION_BITS: r_res_bits <= i_cfg_data[4:0];
                REG_MSB_BITS_USED:   r_msb_bits <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign res_eff = res_clamp(r_res_bits);
    assign mb_eff  = msb_clamp(r_msb_bits);
    assign o_full  = q_stat.full;

    // front: accept and build raw count
    mavt_front u_front (
        .i_res  (res_eff),
        .i_mb   (mb_eff),
        .i_push (i_push),
        .i_full (q_stat.full),
        .i_in   (i_in),
        .o_wr   (front_wr),
        .o_job  (front_job)
    );

    // decoupling queue
    mavt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_data  (front_job),
        .i_rd    (q_pop),
        .o_data  (q_job),
        .o_stat  (q_stat)
    );

    // back: turn tracking, scaling, velocity divide, result register
    mavt_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (res_eff),
        .i_q_empty (q_stat.empty),
        .i_job     (q_job),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_out     (o_out)
    );

    // back end only takes an item the queue holds
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end popped an empty queue");

    // front end never writes a full queue
    a_wr_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_wr |-> !q_stat.full)
        else $error("front end wrote a full queue");

    // no result after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result pending after reset");

endmodule

FILE: tb/multiturn_angle_velocity_tracker_core_tb.sv
`timescale 1ns / 100ps

module multiturn_angle_velocity_tracker_core_tb;
    import mavt_pkg::*;

    localparam int FRAC_BITS = 16;
    // cycles without any accepted item before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // 2*pi in Q28, as the block scales counts
    localparam logic [63:0] TWO_PI_FIX = 64'h6487_ED51;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_push     = 1'b0;
    logic                  o_full;
    t_in                   i_in       = '0;
    logic                  o_empty;
    logic                  i_pop      = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    multiturn_angle_velocity_tracker_core #(
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_in       (i_in),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Tracker model: its own copy of the registers and of the shaft state
    // ------------------------------------------------------------------
    logic [4:0]         cfg_res;
    logic [3:0]         cfg_msb;
    logic [15:0]        trk_last_count;
    logic [15:0]        trk_turns;
    logic [15:0]        trk_zero;
    logic signed [31:0] trk_last_angle;
    logic [31:0]        trk_last_time;

    t_out expected_motion[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   steady = 1'b0;        // both sides run flat out while set

    // stimulus side: where the shaft is meant to be, and the sender's clock
    int          aim = 0;
    logic [31:0] clock_us = '0;

    // register values outside the legal range are clamped by the block
    function automatic int unsigned eff_res();
        if (cfg_res < 8) return 8;
        if (cfg_res > 16) return 16;
        return cfg_res;
    endfunction

    function automatic int unsigned eff_msb();
        return (cfg_msb > 8) ? 8 : cfg_msb;
    endfunction

    function automatic logic signed [31:0] clip_q(input logic neg, input logic [63:0] mag);
        if (neg) begin
            if (mag >= 64'h8000_0000) return Q_MIN;
            return 32'(64'd0 - mag);
        end
        if (mag >= 64'h8000_0000) return Q_MAX;
        return 32'(mag);
    endfunction

    // counts to radians, rounded half away from zero
    function automatic logic signed [31:0] counts_to_rad(input longint t);
        int unsigned sh;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] prod;
        sh = eff_res() + 28 - FRAC_BITS;
        neg = (t < 0);
        mag = neg ? 64'(-t) : 64'(t);
        prod = mag * TWO_PI_FIX;
        return clip_q(neg, (prod + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic logic [15:0] count_of(input logic [7:0] hi, input logic [7:0] lo);
        int unsigned res;
        int unsigned mb;
        int unsigned lu;
        int unsigned lmask;
        int unsigned c;
        res = eff_res();
        mb = eff_msb();
        lu = (mb > res) ? 0 : res - mb;
        lmask = (lu >= 8) ? 32'hFF : (1 << lu) - 1;
        c = (lo & lmask) + ((hi & ((1 << mb) - 1)) << lu);
        return 16'(c & ((1 << res) - 1));
    endfunction

    // wrap detection against the previous count, then the multi-turn angle
    function automatic logic signed [31:0] follow_turns(input logic [15:0] c);
        int unsigned res;
        longint      d;
        longint      ad;
        longint      t;
        res = eff_res();
        d = longint'(c) - longint'(trk_last_count);
        ad = (d < 0) ? -d : d;
        if (ad * 5 > (longint'(4) << res)) begin
            trk_turns = (d > 0) ? trk_turns - 16'd1 : trk_turns + 16'd1;
        end
        trk_last_count = c;
        t = longint'($signed(trk_turns)) * (longint'(1) << res)
            + longint'(c) - longint'(trk_zero);
        return counts_to_rad(t);
    endfunction

    function automatic t_out predict_motion(input t_in item);
        t_out               r;
        logic [31:0]        dt;
        logic [15:0]        c;
        logic signed [31:0] a;
        longint             diff;
        logic               neg;
        logic [63:0]        mag;
        r = '0;
        case (t_op'(item.op))
            OP_SAMPLE: begin
                dt = item.time_us - trk_last_time;
                if (dt == 0 || dt > DT_MAX) dt = 32'(DT_DEFAULT);
                a = follow_turns(count_of(item.msb_byte, item.lsb_byte));
                diff = longint'(a) - longint'(trk_last_angle);
                neg = (diff < 0);
                mag = neg ? 64'(-diff) : 64'(diff);
                r.angle_rad = a;
                r.velocity_rad_s = clip_q(neg, (mag * 64'(US_PER_S) + 64'(dt / 2)) / 64'(dt));
                trk_last_angle = a;
                trk_last_time = item.time_us;
            end
            OP_SET_ZERO: begin
                c = count_of(item.msb_byte, item.lsb_byte);
                a = follow_turns(c);
                r.zero_shift_rad = (a == Q_MIN) ? Q_MAX : -a;
                trk_zero = c;
                trk_turns = '0;
            end
            OP_CLEAR_ZERO: begin
                r.zero_shift_rad = counts_to_rad(-longint'(trk_zero));
                trk_zero = '0;
                trk_turns = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic t_in raw_item(input t_op op, input logic [7:0] hi,
                                     input logic [7:0] lo, input logic [31:0] t);
        t_in it;
        it.op = op;
        it.msb_byte = hi;
        it.lsb_byte = lo;
        it.time_us = t;
        return it;
    endfunction

    // spread a count over the two bytes for the current layout; unused bits get noise
    function automatic t_in pack_count(input t_op op, input int unsigned count,
                                       input logic [31:0] t);
        int unsigned mb;
        int unsigned lu;
        logic [7:0]  lmask;
        logic [7:0]  mmask;
        mb = eff_msb();
        lu = eff_res() - mb;
        lmask = (lu >= 8) ? 8'hFF : 8'((1 << lu) - 1);
        mmask = 8'((1 << mb) - 1);
        return raw_item(op, (8'(count >> lu) & mmask) | (8'($urandom) & ~mmask),
                        (8'(count) & lmask) | (8'($urandom) & ~lmask), t);
    endfunction

    // ------------------------------------------------------------------
    // Item side: drive at the falling edge, accept on push && !full
    // ------------------------------------------------------------------
    task automatic send_item(input t_in item);
        while (!steady && $urandom_range(99) < 38) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_push = 1'b1;
        i_in = item;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        expected_motion.push_back(predict_motion(item));
        @(negedge i_clk);
        i_push = 1'b0;
    endtask

    task automatic sample_at(input int unsigned count, input logic [31:0] t);
        send_item(pack_count(OP_SAMPLE, count, t));
        aim = count;
    endtask

    // every item gives a result, so the block is idle once the queue has drained
    task automatic wait_idle(input int tail);
        i_push = 1'b0;
        while (expected_motion.size() != 0) @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [4:0] res, input logic [3:0] msb);
        wait_idle(8);
        i_cfg_we = 1'b1;
        i_cfg_idx = REG_RESOLUTION_BITS;
        i_cfg_data = res;
        cfg_res = res;
        @(negedge i_clk);
        i_cfg_idx = REG_MSB_BITS_USED;
        i_cfg_data = CFG_DATA_W'(msb);
        cfg_msb = msb;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        aim = aim & ((1 << eff_res()) - 1);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, check against the oldest prediction
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_pop <= steady || ($urandom_range(99) >= 38);
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_motion.size() == 0) begin
                $display("%0t: unexpected result angle %0d vel %0d shift %0d", $time,
                         o_out.angle_rad, o_out.velocity_rad_s, o_out.zero_shift_rad);
                mismatches++;
            end else begin
                want = expected_motion.pop_front();
                if (o_out !== want) begin
                    $display("%0t: expected angle %0d vel %0d shift %0d, got %0d %0d %0d",
                             $time, want.angle_rad, want.velocity_rad_s,
                             want.zero_shift_rad, o_out.angle_rad, o_out.velocity_rad_s,
                             o_out.zero_shift_rad);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: any accepted item on either side restarts the count
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("multiturn_angle_velocity_tracker_core_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // all-zero and all-one bytes under the reset layout (12 bits, 4 in the high byte)
    task automatic test_byte_extremes();
        send_item(raw_item(OP_SAMPLE, 8'h00, 8'h00, 32'd0));     // dt of zero
        send_item(raw_item(OP_SAMPLE, 8'hFF, 8'hFF, 32'd1000));  // full-scale jump: a turn back
        send_item(raw_item(OP_SAMPLE, 8'hFF, 8'h00, 32'd2000));
        send_item(raw_item(OP_SAMPLE, 8'h00, 8'hFF, 32'd3000));
    endtask

    // one-microsecond steps saturate the velocity; the 0.5 s limit and a stamp wrap
    task automatic test_time_step();
        sample_at(12'h800, 32'd3001);
        sample_at(12'h000, 32'd3002);
        sample_at(12'h400, 32'd503002);        // exactly 0.5 s, kept
        sample_at(12'h500, 32'd1003003);       // just over, taken as 1 ms
        sample_at(12'h600, 32'hFFFF_FFF0);
        sample_at(12'h680, 32'h0000_0010);     // stamp wraps through zero
    endtask

    // turn counting either way and both sides of the 0.8 rev threshold
    task automatic test_turn_wrap();
        sample_at(12'hF00, 32'd100);
        sample_at(12'h100, 32'd200);           // forward wrap
        sample_at(0, 32'd300);
        sample_at(3276, 32'd400);              // just under 0.8 rev: no wrap
        sample_at(0, 32'd500);
        sample_at(3277, 32'd600);              // just over: a turn back
        sample_at(12'h010, 32'd700);
    endtask

    task automatic test_zero_ops();
        send_item(pack_count(OP_SET_ZERO, 12'h123, 32'd750));
        sample_at(12'h123, 32'd800);
        sample_at(12'h200, 32'd900);
        send_item(pack_count(OP_SET_ZERO, 12'hFF0, 32'd950));  // wraps while zeroing
        send_item(raw_item(OP_CLEAR_ZERO, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        send_item(raw_item(OP_CLEAR_ZERO, 8'h00, 8'h00, 32'd0));
        send_item(raw_item(OP_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        send_item(raw_item(OP_SET_ZERO, 8'h00, 8'h00, 32'd0));
    endtask

    // next sender timestamp: mostly short steps, some repeats, long gaps and wild jumps
    function automatic logic [31:0] next_stamp();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 78)      clock_us = clock_us + $urandom_range(1, 3000);
        else if (roll < 85) clock_us = clock_us;
        else if (roll < 91) clock_us = clock_us + $urandom_range(500001, 5000000);
        else if (roll < 95) clock_us = clock_us + 500000 + $urandom_range(1);
        else                clock_us = $urandom;
        return clock_us;
    endfunction

    // mostly a shaft moving smoothly with the odd wrap, mixed with zero operations
    // and noise
    task automatic test_random_tracking(input int n);
        int          rev;
        int          delta;
        int unsigned roll;
        logic [31:0] t;
        rev = 1 << eff_res();
        repeat (n) begin
            roll = $urandom_range(99);
            t = next_stamp();
            if (roll < 78) begin
                case ($urandom_range(9))
                    6, 7:    delta = $urandom_range(rev - 1);
                    8: begin
                        delta = (4 * rev) / 5 + int'($urandom_range(2)) - 1;
                        if ($urandom_range(1)) delta = -delta;
                    end
                    9:       delta = 0;
                    default: delta = int'($urandom_range(rev / 2)) - rev / 4;
                endcase
                aim = (aim + delta) & (rev - 1);
                send_item(pack_count(OP_SAMPLE, aim, t));
            end else if (roll < 86) begin
                send_item(pack_count(OP_SET_ZERO, aim, t));
            end else if (roll < 92) begin
                send_item(raw_item(OP_CLEAR_ZERO, 8'($urandom), 8'($urandom), t));
            end else if (roll < 95) begin
                send_item(raw_item(OP_NONE, 8'($urandom), 8'($urandom), t));
            end else begin
                send_item(raw_item(OP_SAMPLE, 8'($urandom), 8'($urandom), t));
            end
        end
    endtask

    // register sweep: both extremes of each, odd layouts and clamped values
    task automatic test_layouts();
        logic [4:0] res_list[10] = '{5'd12, 5'd8, 5'd8, 5'd16, 5'd16, 5'd10, 5'd14,
                                     5'd31, 5'd2, 5'd13};
        logic [3:0] msb_list[10] = '{4'd4, 4'd0, 4'd8, 4'd8, 4'd0, 4'd3, 4'd7,
                                     4'd15, 4'd9, 4'd5};
        for (int k = 0; k < 10; k++) begin
            if (k != 0) set_config(res_list[k], msb_list[k]);
            test_random_tracking(130);
        end
    endtask

    // no idling on either side, so the input queue fills behind the divider
    task automatic test_back_to_back();
        set_config(5'd16, 4'd8);
        steady = 1'b1;
        test_random_tracking(200);
        wait_idle(2);
        steady = 1'b0;
    endtask

    initial begin
        cfg_res = RES_RESET;
        cfg_msb = MSB_RESET;
        trk_last_count = '0;
        trk_turns = '0;
        trk_zero = '0;
        trk_last_angle = '0;
        trk_last_time = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_byte_extremes();
        test_time_step();
        test_turn_wrap();
        test_zero_ops();
        test_layouts();
        test_back_to_back();

        wait_idle(40);
        if (mismatches == 0) begin
            $display("multiturn_angle_velocity_tracker_core_tb passed");
        end else begin
            $display("multiturn_angle_velocity_tracker_core_tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/mavt_pkg.sv
hdl/mavt_front.sv
hdl/mavt_queue.sv
hdl/mavt_back.sv
hdl/multiturn_angle_velocity_tracker_core.sv
tb/multiturn_angle_velocity_tracker_core_tb.sv
